### rtl/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, codes and the CRC-16 (reflected, poly 0x8408) byte update.
// ----------------------------------------------------------------------------
package crcfr_pkg;

	localparam logic [15:0] CRC_POLY      = 16'h8408;
	localparam logic [15:0] MIN_FRAME     = 16'd12;
	localparam logic [15:0] RST_START     = 16'h557E;
	localparam logic [15:0] RST_SEED      = 16'hFFFF;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CRC_ERR = 2'd1;
	localparam logic [1:0] ST_LEN_ERR = 2'd2;

	localparam logic [1:0] CRC_NONE = 2'd0;
	localparam logic [1:0] CRC_DATA = 2'd1;
	localparam logic [1:0] CRC_LO   = 2'd2;
	localparam logic [1:0] CRC_HI   = 2'd3;

	localparam logic [2:0] CAP_NONE   = 3'd0;
	localparam logic [2:0] CAP_LEN_LO = 3'd1;
	localparam logic [2:0] CAP_LEN_HI = 3'd2;
	localparam logic [2:0] CAP_ID_LO  = 3'd3;
	localparam logic [2:0] CAP_ID_HI  = 3'd4;
	localparam logic [2:0] CAP_PAY    = 3'd5;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_SEED  = 2'd1;
	localparam logic [1:0] REG_CHECK = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic [1:0] crc_op;
		logic [2:0] cap;
		logic       last;
		logic       len_err;
	} rec_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] code;
		logic [15:0] length;
		logic [7:0]  payload;
	} result_t;

	typedef struct packed {
		logic [15:0] start_word;
		logic [15:0] crc_seed;
		logic        crc_check_on;
	} cfg_t;

	function automatic logic [15:0] crc_tab(input logic [7:0] i);
		logic [15:0] c;
		c = {8'h00, i};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		return {8'h00, crc[15:8]} ^ crc_tab(crc[7:0] ^ b);
	endfunction

endpackage

### rtl/crcfr_fifo.sv
// ----------------------------------------------------------------------------
// crcfr_fifo
// Two-entry register queue.
// ----------------------------------------------------------------------------
module crcfr_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wp_q <= ~wp_q;
			if (do_pop)
				rp_q <= ~rp_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

### rtl/crcfr_front.sv
// ----------------------------------------------------------------------------
// crcfr_front
// Tracks the byte position in the frame, checks the start word and length
// range, and tags each byte with its role for the back end.
// ----------------------------------------------------------------------------
module crcfr_front
	import crcfr_pkg::*;
#(
	parameter int MAX_FRAME = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] start_word,
	output logic        emit,
	output rec_t        rec
);

	localparam int CW = $clog2(MAX_FRAME);

	logic [CW-1:0] cnt_q;
	logic [15:0]   len_q;
	logic [CW-1:0] cnt_d;
	logic [15:0]   len_d;
	logic [15:0]   len_w;
	logic [16:0]   idx_p4;
	logic [16:0]   idx_p3;
	logic [16:0]   idx_p1;
	logic [16:0]   len17;

	always_comb begin
		len_w  = (cnt_q == CW'(3)) ? {rx_byte, len_q[7:0]} : len_q;
		len17  = {1'b0, len_w};
		idx_p4 = 17'(cnt_q) + 17'd4;
		idx_p3 = 17'(cnt_q) + 17'd3;
		idx_p1 = 17'(cnt_q) + 17'd1;
		emit   = 1'b0;
		cnt_d  = cnt_q;
		len_d  = len_q;
		rec    = '0;
		rec.data   = rx_byte;
		rec.crc_op = CRC_NONE;
		rec.cap    = CAP_NONE;
		if (cnt_q == '0) begin
			if (rx_byte == start_word[7:0]) begin
				emit       = 1'b1;
				rec.start  = 1'b1;
				rec.crc_op = CRC_DATA;
				cnt_d      = CW'(1);
			end
		end else if (cnt_q == CW'(1) && rx_byte != start_word[15:8]) begin
			cnt_d = '0;
		end else begin
			emit  = 1'b1;
			cnt_d = cnt_q + CW'(1);
			if (cnt_q < CW'(4) || idx_p4 < len17)
				rec.crc_op = CRC_DATA;
			else if (idx_p4 == len17)
				rec.crc_op = CRC_LO;
			else if (idx_p3 == len17)
				rec.crc_op = CRC_HI;
			if (cnt_q == CW'(2)) begin
				rec.cap = CAP_LEN_LO;
				len_d   = {len_q[15:8], rx_byte};
			end else if (cnt_q == CW'(3)) begin
				rec.cap = CAP_LEN_HI;
				len_d   = len_w;
				if (len_w < MIN_FRAME || len_w > 16'(MAX_FRAME)) begin
					rec.len_err = 1'b1;
					cnt_d       = '0;
				end
			end else if (cnt_q == CW'(6)) begin
				rec.cap = CAP_ID_LO;
			end else if (cnt_q == CW'(7)) begin
				rec.cap = CAP_ID_HI;
			end else if (cnt_q == CW'(8) && idx_p4 < len17) begin
				rec.cap = CAP_PAY;
			end
			if (cnt_q >= CW'(4) && idx_p1 == len17) begin
				rec.last = 1'b1;
				cnt_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			len_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_d;
			len_q <= len_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		17'(cnt_q) < 17'(MAX_FRAME))
		else $error("frame position past maximum frame size");

	a_len_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= CW'(4) |-> (len_q >= MIN_FRAME && len_q <= 16'(MAX_FRAME)))
		else $error("frame body with out-of-range length");

	a_last_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit && (rec.last || rec.len_err) |=> cnt_q == '0)
		else $error("receiver not rearmed after frame end");

endmodule

### rtl/crcfr_back.sv
// ----------------------------------------------------------------------------
// crcfr_back
// Runs the CRC, captures header fields and builds one result per frame.
// ----------------------------------------------------------------------------
module crcfr_back
	import crcfr_pkg::*;
(
	input  logic    clk,
	input  logic    take,
	input  rec_t    rec,
	input  cfg_t    cfg,
	output logic    res_valid,
	output result_t res
);

	logic [15:0] crc_q;
	logic [7:0]  crc_lo_q;
	logic        fail_q;
	logic [15:0] len_q;
	logic [15:0] id_q;
	logic [7:0]  pay_q;

	always_comb begin
		res_valid = take && (rec.last || rec.len_err);
		if (rec.len_err) begin
			res.status  = ST_LEN_ERR;
			res.code    = '0;
			res.length  = {rec.data, len_q[7:0]};
			res.payload = '0;
		end else begin
			res.status  = (cfg.crc_check_on && fail_q) ? ST_CRC_ERR : ST_OK;
			res.code    = id_q;
			res.length  = len_q;
			res.payload = pay_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (rec.start) begin
				crc_q    <= crc_step(cfg.crc_seed, rec.data);
				crc_lo_q <= '0;
				fail_q   <= 1'b0;
				id_q     <= '0;
				pay_q    <= '0;
			end else begin
				unique case (rec.crc_op)
					CRC_DATA: crc_q <= crc_step(crc_q, rec.data);
					CRC_LO:   crc_lo_q <= rec.data;
					CRC_HI:   fail_q <= (crc_lo_q != crc_q[7:0]) || (rec.data != crc_q[15:8]);
					default: ;
				endcase
				unique case (rec.cap)
					CAP_LEN_LO: len_q[7:0]  <= rec.data;
					CAP_LEN_HI: len_q[15:8] <= rec.data;
					CAP_ID_LO:  id_q[7:0]   <= rec.data;
					CAP_ID_HI:  id_q[15:8]  <= rec.data;
					CAP_PAY:    pay_q       <= rec.data;
					default: ;
				endcase
			end
		end
	end

endmodule

### rtl/crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Byte-serial frame receiver with start-word, length and CRC-16 checks.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while full is low. The front end
// tracks the frame position and checks the start word and length range;
// each frame byte is tagged and queued to the back end, which runs the table CRC
// update and builds the result. Results leave through a two-entry queue, so
// a result transaction waiting on pop blocks input only once that queue and
// the queue to the back end are full. Sustained rate is one byte per cycle
// while full is low, limited by the single CRC update per cycle.
module crc16_frame_receiver
	import crcfr_pkg::*;
#(
	parameter int MAX_FRAME = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  frame_status,
	output logic [15:0] message_code,
	output logic [15:0] total_length,
	output logic [7:0]  first_payload_byte,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t    cfg_q;
	logic    accept;
	logic    emit;
	rec_t    rec_in;
	rec_t    rec_out;
	logic    mid_full;
	logic    mid_empty;
	logic    out_full;
	logic    take;
	logic    res_valid;
	result_t res;
	result_t res_out;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_word   <= RST_START;
			cfg_q.crc_seed     <= RST_SEED;
			cfg_q.crc_check_on <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_START: cfg_q.start_word   <= pwdata[15:0];
				REG_SEED:  cfg_q.crc_seed     <= pwdata[15:0];
				REG_CHECK: cfg_q.crc_check_on <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_START: prdata = {16'h0000, cfg_q.start_word};
			REG_SEED:  prdata = {16'h0000, cfg_q.crc_seed};
			REG_CHECK: prdata = {31'h0, cfg_q.crc_check_on};
			default:   prdata = '0;
		endcase
	end

	assign full   = mid_full;
	assign accept = push && !mid_full;
	assign take   = !mid_empty && !out_full;

	crcfr_front #(.MAX_FRAME(MAX_FRAME)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.start_word (cfg_q.start_word),
		.emit       (emit),
		.rec        (rec_in)
	);

	crcfr_fifo #(.W($bits(rec_t))) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && emit),
		.wdata  (rec_in),
		.full   (mid_full),
		.pop    (take),
		.rdata  (rec_out),
		.empty  (mid_empty)
	);

	crcfr_back u_back (
		.clk       (clk),
		.take      (take),
		.rec       (rec_out),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	crcfr_fifo #(.W($bits(result_t))) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign frame_status       = res_out.status;
	assign message_code       = res_out.code;
	assign total_length       = res_out.length;
	assign first_payload_byte = res_out.payload;

endmodule

### dv/tb_crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_crc16_frame_receiver
// Byte-stream testbench for the CRC-16 frame receiver. Frames are built with
// the current start word and seed, fed byte by byte through the push/full
// side, and every result transaction popped from the result side is checked
// field by field against a cycle-free predictor of the deframer. The run
// covers framing errors, length range errors, CRC errors with the check on
// and off, several register settings, random idling and long result stalls.
// ----------------------------------------------------------------------------
module tb_crc16_frame_receiver
	import crcfr_pkg::*;
;

	localparam int MAX_FRAME   = 255;
	localparam int ITEM_TARGET = 950;
	localparam int IDLE_GAP    = 8;
	localparam int CYCLE_LIMIT = 300000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [1:0]  frame_status;
	logic [15:0] message_code;
	logic [15:0] total_length;
	logic [7:0]  first_payload_byte;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	crc16_frame_receiver #(.MAX_FRAME(MAX_FRAME)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.frame_status(frame_status),
		.message_code(message_code),
		.total_length(total_length),
		.first_payload_byte(first_payload_byte),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// deframer state as predicted
	cfg_t        cfg;
	logic [7:0]  rx_pos;
	logic [15:0] rx_len;
	logic [15:0] rx_crc;
	logic [15:0] rx_id;
	logic [7:0]  rx_pay;
	logic [7:0]  rx_crc_lo;
	logic        rx_crc_bad;

	result_t     pending_frames[$];
	int          err_count   = 0;
	int          bytes_sent  = 0;
	int          cycle_count = 0;
	bit          tx_idle     = 1'b0;
	bit          rx_idle     = 1'b0;
	int          hold_cycles = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		return v;
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		result_t     r;
		logic [15:0] at;
		at = {8'h00, rx_pos};
		if (rx_pos == 8'd0) begin
			if (b == cfg.start_word[7:0]) begin
				rx_crc     = crc16_next(cfg.crc_seed, b);
				rx_len     = '0;
				rx_id      = '0;
				rx_pay     = '0;
				rx_crc_lo  = '0;
				rx_crc_bad = 1'b0;
				rx_pos     = 8'd1;
			end
			return;
		end
		if (rx_pos == 8'd1 && b != cfg.start_word[15:8]) begin
			rx_pos = 8'd0;
			return;
		end
		if (rx_pos == 8'd2)
			rx_len = {8'h00, b};
		if (rx_pos == 8'd3) begin
			rx_len[15:8] = b;
			if (rx_len < MIN_FRAME || rx_len > MAX_FRAME) begin
				r.status  = ST_LEN_ERR;
				r.code    = '0;
				r.length  = rx_len;
				r.payload = '0;
				pending_frames.push_back(r);
				rx_pos = 8'd0;
				return;
			end
		end
		if (rx_pos < 8'd4 || at + 16'd4 < rx_len)
			rx_crc = crc16_next(rx_crc, b);
		else if (at + 16'd4 == rx_len)
			rx_crc_lo = b;
		else if (at + 16'd3 == rx_len)
			rx_crc_bad = (rx_crc_lo != rx_crc[7:0]) || (b != rx_crc[15:8]);
		if (rx_pos == 8'd6)
			rx_id = {8'h00, b};
		else if (rx_pos == 8'd7)
			rx_id[15:8] = b;
		else if (rx_pos == 8'd8 && at + 16'd4 < rx_len)
			rx_pay = b;
		rx_pos = rx_pos + 8'd1;
		if (rx_pos >= 8'd5 && {8'h00, rx_pos} == rx_len) begin
			r.status  = (cfg.crc_check_on && rx_crc_bad) ? ST_CRC_ERR : ST_OK;
			r.code    = rx_id;
			r.length  = rx_len;
			r.payload = rx_pay;
			pending_frames.push_back(r);
			rx_pos = 8'd0;
		end
	endfunction

	function automatic void note_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (err_count < 10)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
		err_count++;
	endfunction

	// result side: random pop gaps, one-shot long hold on request
	initial begin : frame_checker
		int      wait_cycles;
		result_t want;
		pop <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			wait_cycles = rx_idle ? $urandom_range(0, 13) : 0;
			if (hold_cycles != 0) begin
				wait_cycles = hold_cycles;
				hold_cycles = 0;
			end
			if (wait_cycles != 0) begin
				pop <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			if (pending_frames.size() == 0) begin
				if (err_count < 10)
					$display("unexpected result transaction: status %0d length %h",
						frame_status, total_length);
				err_count++;
			end else begin
				want = pending_frames.pop_front();
				if (frame_status != want.status)
					note_mismatch("frame_status", 16'(want.status), 16'(frame_status));
				if (message_code != want.code)
					note_mismatch("message_code", want.code, message_code);
				if (total_length != want.length)
					note_mismatch("total_length", want.length, total_length);
				if (first_payload_byte != want.payload)
					note_mismatch("first_payload_byte", 16'(want.payload),
						16'(first_payload_byte));
			end
		end
	end

	// called at a clock edge; leaves push high when the next byte follows at once
	task automatic send_byte(input logic [7:0] b);
		int gap;
		push    <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_byte(b);
		bytes_sent++;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// fill < 0 gives random body bytes; cut > 0 sends only the first cut bytes
	task automatic send_frame(input logic [15:0] len, input logic [15:0] id, input bit bad_crc,
			input int fill, input int cut);
		logic [7:0]  fb[$];
		logic [15:0] crc;
		int          n;
		n = (len < MIN_FRAME || len > MAX_FRAME) ? 4 : int'(len);
		for (int i = 0; i < n; i++)
			fb.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
		fb[0] = cfg.start_word[7:0];
		fb[1] = cfg.start_word[15:8];
		fb[2] = len[7:0];
		fb[3] = len[15:8];
		if (n > 4) begin
			fb[6] = id[7:0];
			fb[7] = id[15:8];
			crc = cfg.crc_seed;
			for (int i = 0; i < n - 4; i++)
				crc = crc16_next(crc, fb[i]);
			if (bad_crc)
				crc ^= 16'($urandom_range(1, 16'hFFFF));
			fb[n-4] = crc[7:0];
			fb[n-3] = crc[15:8];
		end
		if (cut > 0 && cut < n)
			n = cut;
		for (int i = 0; i < n; i++)
			send_byte(fb[i]);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [15:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_START: cfg.start_word   = v;
			REG_SEED:  cfg.crc_seed     = v;
			REG_CHECK: cfg.crc_check_on = v[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// stop sending, let every expected result drain, then cover the pipeline tail
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 16'($urandom_range(12, 24));
		else if (r < 98)
			return 16'($urandom_range(25, 64));
		return 16'($urandom_range(200, MAX_FRAME));
	endfunction

	task automatic random_burst(input int stop_at);
		int          sel;
		int          k;
		logic [15:0] len;
		while (bytes_sent < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				send_frame(pick_length(), 16'($urandom), sel < 12, -1, 0);
			end else if (sel < 80) begin
				len = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 11))
					: 16'($urandom_range(256, 65535));
				send_frame(len, 16'($urandom), 1'b0, -1, 0);
			end else if (sel < 90) begin
				k = $urandom_range(1, 6);
				repeat (k) send_byte(8'($urandom));
			end else if (sel < 95) begin
				send_byte(cfg.start_word[7:0]);
				send_byte(8'($urandom));
			end else begin
				len = pick_length();
				send_frame(len, 16'($urandom), 1'b0, -1, $urandom_range(4, int'(len) - 1));
			end
		end
	endtask

	task automatic set_registers(input logic [15:0] start_w, input logic [15:0] seed,
			input bit check_on);
		wait_idle();
		reg_write(REG_START, start_w);
		reg_write(REG_SEED, seed);
		reg_write(REG_CHECK, {15'($urandom), check_on});
	endtask

	task automatic test_reset_defaults();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_frame(16'd12, 16'h0000, 1'b0, 0, 0);
		send_frame(16'd13, 16'hFFFF, 1'b1, 255, 0);
		send_frame(16'd16, 16'($urandom), 1'b0, -1, 0);
	endtask

	task automatic test_framing_errors();
		send_byte(~cfg.start_word[7:0]);
		send_byte(cfg.start_word[7:0]);
		send_byte(cfg.start_word[7:0]);
		send_byte(cfg.start_word[15:8]);
		send_frame(16'd11, 16'h0000, 1'b0, -1, 0);
		send_frame(16'd0, 16'h0000, 1'b0, -1, 0);
		send_frame(16'd256, 16'h0000, 1'b0, -1, 0);
		send_frame(16'hFFFF, 16'h0000, 1'b0, -1, 0);
	endtask

	task automatic test_register_sweep();
		set_registers(16'h0000, 16'h0000, 1'b0);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		random_burst(bytes_sent + 80);
		set_registers(16'hFFFF, 16'hFFFF, 1'b1);
		tx_idle = 1'b1;
		rx_idle = 1'b0;
		random_burst(bytes_sent + 80);
		set_registers(16'($urandom), 16'($urandom), 1'b0);
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		random_burst(bytes_sent + 80);
		set_registers(16'($urandom), 16'($urandom), 1'b1);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		random_burst(bytes_sent + 80);
	endtask

	task automatic test_backpressure();
		set_registers(RST_START, RST_SEED, 1'b1);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_cycles = 300;
		repeat (24) send_frame(16'd12, 16'($urandom), $urandom_range(0, 3) == 0, -1, 0);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		set_registers(16'($urandom), 16'($urandom), 1'b1);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_frame(16'(MAX_FRAME), 16'($urandom), 1'b0, -1, 0);
		while (bytes_sent < ITEM_TARGET) begin
			tx_idle = 1'($urandom_range(0, 1));
			rx_idle = 1'($urandom_range(0, 1));
			random_burst(bytes_sent + 60);
		end
	endtask

	initial begin
		arst_n  <= 1'b0;
		push    <= 1'b0;
		rx_byte <= 8'h00;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		cfg.start_word   = RST_START;
		cfg.crc_seed     = RST_SEED;
		cfg.crc_check_on = 1'b1;
		rx_pos     = '0;
		rx_len     = '0;
		rx_crc     = RST_SEED;
		rx_id      = '0;
		rx_pay     = '0;
		rx_crc_lo  = '0;
		rx_crc_bad = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_framing_errors();
		test_register_sweep();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (20) @(posedge clk);

		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
